// File: rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque block.
// ----------------------------------------------------------------------------
package cdq_pkg;

	// Width of one stored data word.
	localparam int DATA_W = 32;

	// Width of the capacity value written on the capacity port.
	localparam int CAP_W = 11;

	// Operation codes carried on the op port.
	typedef enum logic [2:0] {
		OP_INSERT_FRONT = 3'd0,
		OP_INSERT_REAR  = 3'd1,
		OP_DELETE_FRONT = 3'd2,
		OP_DELETE_REAR  = 3'd3,
		OP_QUERY        = 3'd4
	} op_t;

	// Status of one operation as seen after the state update.
	typedef struct packed {
		logic ok;
		logic empty;
		logic full;
	} cdq_status_t;

endpackage

// File: rtl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read ports return the old word on a same-address write.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// File: rtl/cdq_ptr.sv
// ----------------------------------------------------------------------------
// cdq_ptr
// Head, rear and count bookkeeping for the deque, plus the capacity register.
// ----------------------------------------------------------------------------
module cdq_ptr
	import cdq_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [2:0]               op,
	input  logic                     cfg_we,
	input  logic [CAP_W-1:0]         cfg_wdata,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output logic [$clog2(DEPTH)-1:0] front_addr,
	output logic [$clog2(DEPTH)-1:0] rear_addr,
	output cdq_status_t              status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;

	logic [AW-1:0] head_q, rear_q, cap_m1_q;
	logic [CW-1:0] count_q, cap_q;
	logic [AW-1:0] head_n, rear_n;
	logic [CW-1:0] count_n;
	logic          ok_n, we_n;
	logic          full, empty;
	logic [EW-1:0] cfg_ext, cfg_eff;
	logic [AW-1:0] head_dec, head_inc, rear_dec, rear_inc;

	// Clamp a written capacity into the range 1 to DEPTH.
	always_comb begin
		cfg_ext = EW'(cfg_wdata);
		cfg_eff = cfg_ext;
		if (cfg_ext == '0) begin
			cfg_eff = EW'(1);
		end else if (cfg_ext > EW'(DEPTH)) begin
			cfg_eff = EW'(DEPTH);
		end
	end

	// Single-step wraps against the capacity.
	assign head_dec = (head_q == '0) ? cap_m1_q : head_q - AW'(1);
	assign head_inc = (head_q == cap_m1_q) ? '0 : head_q + AW'(1);
	assign rear_dec = (rear_q == '0) ? cap_m1_q : rear_q - AW'(1);
	assign rear_inc = (rear_q == cap_m1_q) ? '0 : rear_q + AW'(1);

	assign full  = (count_q >= cap_q);
	assign empty = (count_q == '0);

	// Operation decode: the rear pointer always sits at head + count - 1.
	always_comb begin
		head_n  = head_q;
		rear_n  = rear_q;
		count_n = count_q;
		ok_n    = 1'b0;
		we_n    = 1'b0;
		mem_waddr = head_dec;
		unique case (op_t'(op))
			OP_INSERT_FRONT: begin
				mem_waddr = head_dec;
				if (!full) begin
					head_n  = head_dec;
					count_n = count_q + CW'(1);
					ok_n    = 1'b1;
					we_n    = 1'b1;
				end
			end
			OP_INSERT_REAR: begin
				mem_waddr = rear_inc;
				if (!full) begin
					rear_n  = rear_inc;
					count_n = count_q + CW'(1);
					ok_n    = 1'b1;
					we_n    = 1'b1;
				end
			end
			OP_DELETE_FRONT: begin
				if (!empty) begin
					head_n  = head_inc;
					count_n = count_q - CW'(1);
					ok_n    = 1'b1;
				end
			end
			OP_DELETE_REAR: begin
				if (!empty) begin
					rear_n  = rear_dec;
					count_n = count_q - CW'(1);
					ok_n    = 1'b1;
				end
			end
			OP_QUERY: begin
				ok_n = 1'b1;
			end
			default: begin
				ok_n = 1'b0;
			end
		endcase
	end

	assign mem_we       = accept && we_n;
	assign front_addr   = head_n;
	assign rear_addr    = rear_n;
	assign status.ok    = ok_n;
	assign status.empty = (count_n == '0);
	assign status.full  = (count_n >= cap_q);

	// State registers; a capacity write also empties the deque.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CW'(DEPTH);
			cap_m1_q <= AW'(DEPTH - 1);
			head_q   <= '0;
			rear_q   <= AW'(DEPTH - 1);
			count_q  <= '0;
		end else if (cfg_we) begin
			cap_q    <= CW'(cfg_eff);
			cap_m1_q <= AW'(cfg_eff - EW'(1));
			head_q   <= '0;
			rear_q   <= AW'(cfg_eff - EW'(1));
			count_q  <= '0;
		end else if (accept) begin
			head_q  <= head_n;
			rear_q  <= rear_n;
			count_q <= count_n;
		end
	end

endmodule

// File: rtl/circular_deque_top.sv
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue of 32-bit words held in a ring memory.
// ----------------------------------------------------------------------------
// A word is taken at the clock edge where start is high and busy is low; at
// that edge the pointers and count update, an insert writes the memory, and
// both read ports of the ring memory fetch the new front and rear entries.
// In the next cycle done is high for exactly one cycle with the result word,
// busy is high, and start is ignored, so a new word is not taken until the
// result is out. The receiver cannot hold results off. A write of
// capacity_in_use empties the deque; the user must make it only while the
// block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module circular_deque_top
	import cdq_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               op,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic                     ok,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] rear_value,
	output logic                     is_empty,
	output logic                     is_full,
	input  logic                     capacity_we,
	input  logic [CAP_W-1:0]         capacity_in_use
);

	localparam int AW = $clog2(DEPTH);

	logic              accept;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr, front_addr, rear_addr;
	logic [DATA_W-1:0] rd_front, rd_rear;
	cdq_status_t       status, status_s1;
	logic              valid_s1, fwd_front_s1, fwd_rear_s1;
	logic [DATA_W-1:0] wdata_s1;

	assign accept = start && !busy;

	// Pointer and count bookkeeping.
	cdq_ptr #(.DEPTH(DEPTH)) u_ptr (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (op),
		.cfg_we     (capacity_we),
		.cfg_wdata  (capacity_in_use),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.front_addr (front_addr),
		.rear_addr  (rear_addr),
		.status     (status)
	);

	// Ring memory.
	cdq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (value),
		.re      (accept),
		.raddr_a (front_addr),
		.raddr_b (rear_addr),
		.rdata_a (rd_front),
		.rdata_b (rd_rear)
	);

	// Result stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Result stage payload, with forwarding of a word written this edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1    <= status;
			wdata_s1     <= value;
			fwd_front_s1 <= mem_we && (mem_waddr == front_addr);
			fwd_rear_s1  <= mem_we && (mem_waddr == rear_addr);
		end
	end

	assign busy     = valid_s1;
	assign done     = valid_s1;
	assign ok       = status_s1.ok;
	assign is_empty = status_s1.empty;
	assign is_full  = status_s1.full;

	// An empty deque reports all ones on both value ports.
	assign front_value = status_s1.empty ? '1 : (fwd_front_s1 ? wdata_s1 : rd_front);
	assign rear_value  = status_s1.empty ? '1 : (fwd_rear_s1 ? wdata_s1 : rd_rear);

	// Every accepted word yields a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> done)
		else $error("result missing after accepted word");

	// Results never come in two consecutive cycles.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("back-to-back results");

	// A full deque holds at least one entry.
	assert property (@(posedge clk) disable iff (!arst_n) (done && is_full) |-> !is_empty)
		else $error("deque reported both full and empty");

	// An empty deque reports all ones on both value ports.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_empty) |-> (front_value == '1 && rear_value == '1))
		else $error("empty deque reported a stored word");

endmodule
